@@ src/mthd_pkg.sv @@
package mthd_pkg;

  localparam int CHANNELS      = 10;
  localparam int POWER_BITS    = 32;
  localparam int GAIN_BITS     = 16;
  localparam int COUNT_BITS    = 16;
  localparam int CHAN_OUT_BITS = 4;
  localparam int CHAN_W        = $clog2(CHANNELS);
  localparam int PROD_BITS     = POWER_BITS + GAIN_BITS;
  localparam int MEDIAN_RANK   = (CHANNELS - 1) / 2;
  localparam int TOP_RANK      = CHANNELS - 1;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1000);

  typedef logic [POWER_BITS-1:0] power_t;
  typedef power_t [CHANNELS-1:0] power_vec_t;
  typedef logic [CHAN_W-1:0]     chan_t;
  typedef chan_t [CHANNELS-1:0]  rank_vec_t;
  typedef logic [PROD_BITS-1:0]  prod_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [GAIN_BITS-1:0]  gain_t;

  // Load enables of the five pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

@@ src/mthd_lane.sv @@
module mthd_lane (
  input  logic                   clk,
  input  mthd_pkg::pipe_en_t     en,
  input  mthd_pkg::chan_t        lane_id,
  input  mthd_pkg::power_vec_t   power_in,
  output mthd_pkg::chan_t        rank
);

  logic [mthd_pkg::CHANNELS-1:0] below;
  logic [mthd_pkg::CHANNELS-1:0] below_next;
  mthd_pkg::chan_t               rank_next;

  // A channel ranks below this one if its power is smaller, or equal with a
  // lower channel number, which gives the stable ascending order.
  always_comb begin
    for (int j = 0; j < mthd_pkg::CHANNELS; j++) begin
      if (mthd_pkg::CHAN_W'(j) == lane_id) begin
        below_next[j] = 1'b0;
      end else begin
        below_next[j] = (power_in[j] < power_in[lane_id]) ||
                        ((mthd_pkg::CHAN_W'(j) < lane_id) &&
                         (power_in[j] == power_in[lane_id]));
      end
    end
  end

  assign rank_next = mthd_pkg::CHAN_W'($countones(below));

  always_ff @(posedge clk) begin
    if (en.s1) begin
      below <= below_next;
    end
    if (en.s2) begin
      rank <= rank_next;
    end
  end

endmodule

@@ src/mthd_merge.sv @@
module mthd_merge (
  input  logic                   clk,
  input  mthd_pkg::pipe_en_t     en,
  input  mthd_pkg::gain_t        gain,
  input  mthd_pkg::power_vec_t   power_s2,
  input  mthd_pkg::rank_vec_t    rank_s2,
  output mthd_pkg::prod_t        thresh,
  output mthd_pkg::power_t       peak,
  output mthd_pkg::chan_t        peak_chan
);

  mthd_pkg::power_t median_s3;
  mthd_pkg::power_t peak_s3;
  mthd_pkg::chan_t  chan_s3;
  mthd_pkg::power_t median_next;
  mthd_pkg::power_t peak_next;
  mthd_pkg::chan_t  chan_next;

  // Ranks form a permutation, so exactly one lane matches each rank.
  always_comb begin
    median_next = '0;
    peak_next   = '0;
    chan_next   = '0;
    for (int i = 0; i < mthd_pkg::CHANNELS; i++) begin
      if (rank_s2[i] == mthd_pkg::CHAN_W'(mthd_pkg::MEDIAN_RANK)) begin
        median_next = median_next | power_s2[i];
      end
      if (rank_s2[i] == mthd_pkg::CHAN_W'(mthd_pkg::TOP_RANK)) begin
        peak_next = peak_next | power_s2[i];
        chan_next = chan_next | mthd_pkg::CHAN_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      median_s3 <= median_next;
      peak_s3   <= peak_next;
      chan_s3   <= chan_next;
    end
    if (en.s4) begin
      thresh    <= mthd_pkg::PROD_BITS'(median_s3) * mthd_pkg::PROD_BITS'(gain);
      peak      <= peak_s3;
      peak_chan <= chan_s3;
    end
  end

endmodule

@@ src/mthd_eval.sv @@
module mthd_eval (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   lockout,
  input  mthd_pkg::prod_t        thresh,
  input  mthd_pkg::power_t       peak,
  input  mthd_pkg::chan_t        peak_chan,
  output logic                   evaluated,
  output logic                   hit_flag,
  output logic [mthd_pkg::CHAN_OUT_BITS-1:0] hit_channel,
  output mthd_pkg::count_t       channel_count,
  output logic                   start_lockout
);

  logic                               hit_state;
  mthd_pkg::chan_t                    last_channel;
  mthd_pkg::count_t                   hit_counts [mthd_pkg::CHANNELS];
  // Mirrors the count of the last hit channel so the store has one read port.
  mthd_pkg::count_t                   cur_count;
  logic                               hit;
  mthd_pkg::count_t                   count_inc;

  assign hit       = !lockout && (mthd_pkg::PROD_BITS'(peak) > thresh);
  assign count_inc = hit_counts[peak_chan] + mthd_pkg::COUNT_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_state    <= 1'b0;
      last_channel <= '0;
      cur_count    <= '0;
      for (int i = 0; i < mthd_pkg::CHANNELS; i++) begin
        hit_counts[i] <= '0;
      end
    end else if (load && !lockout) begin
      hit_state <= hit;
      if (hit) begin
        last_channel          <= peak_chan;
        cur_count             <= count_inc;
        hit_counts[peak_chan] <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evaluated     <= !lockout;
      start_lockout <= hit;
    end
  end

  // The state only moves when a new result is loaded, so it doubles as the
  // held result payload.
  assign hit_flag      = hit_state;
  assign hit_channel   = mthd_pkg::CHAN_OUT_BITS'(last_channel);
  assign channel_count = cur_count;

endmodule

@@ src/median_threshold_hit_detector_top.sv @@
// Median-relative threshold hit detector. Each request carries ten channel
// powers and a lockout flag; one result comes back per request. The block is
// a five-stage pipeline (lane compares, lane rank count, median and peak
// select, gain multiply, threshold compare with state update). A new request
// can be accepted every cycle unless out_stall holds back a full pipeline;
// stages with no item let requests move up while a result waits on out_stall.
// threshold_gain resets to 1000 and is written via cfg_wr_en and cfg_wr_data;
// the user writes it only while no request is in flight; the block does not enforce it.
module median_threshold_hit_detector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] power_ch0,
  input  logic [31:0] power_ch1,
  input  logic [31:0] power_ch2,
  input  logic [31:0] power_ch3,
  input  logic [31:0] power_ch4,
  input  logic [31:0] power_ch5,
  input  logic [31:0] power_ch6,
  input  logic [31:0] power_ch7,
  input  logic [31:0] power_ch8,
  input  logic [31:0] power_ch9,
  input  logic        lockout_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        evaluated,
  output logic        hit_flag,
  output logic [3:0]  hit_channel,
  output logic [15:0] channel_count,
  output logic        start_lockout
);

  mthd_pkg::gain_t      threshold_gain;
  mthd_pkg::pipe_en_t   en;
  mthd_pkg::power_vec_t power_in;
  mthd_pkg::power_vec_t power_s1;
  mthd_pkg::power_vec_t power_s2;
  mthd_pkg::rank_vec_t  rank_s2;
  mthd_pkg::prod_t      thresh_s4;
  mthd_pkg::power_t     peak_s4;
  mthd_pkg::chan_t      chan_s4;
  logic                 s1_valid;
  logic                 s2_valid;
  logic                 s3_valid;
  logic                 s4_valid;
  logic                 lock_s1;
  logic                 lock_s2;
  logic                 lock_s3;
  logic                 lock_s4;

  always_comb begin
    power_in[0] = power_ch0;
    power_in[1] = power_ch1;
    power_in[2] = power_ch2;
    power_in[3] = power_ch3;
    power_in[4] = power_ch4;
    power_in[5] = power_ch5;
    power_in[6] = power_ch6;
    power_in[7] = power_ch7;
    power_in[8] = power_ch8;
    power_in[9] = power_ch9;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_gain <= mthd_pkg::GAIN_RESET;
    end else if (cfg_wr_en) begin
      threshold_gain <= cfg_wr_data;
    end
  end

  // A stage loads when it is empty or when the stage after it loads.
  always_comb begin
    en.s5 = !out_valid || !out_stall;
    en.s4 = !s4_valid || en.s5;
    en.s3 = !s3_valid || en.s4;
    en.s2 = !s2_valid || en.s3;
    en.s1 = !s1_valid || en.s2;
  end

  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en.s1) begin
        s1_valid <= in_valid;
      end
      if (en.s2) begin
        s2_valid <= s1_valid;
      end
      if (en.s3) begin
        s3_valid <= s2_valid;
      end
      if (en.s4) begin
        s4_valid <= s3_valid;
      end
      if (en.s5) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      power_s1 <= power_in;
      lock_s1  <= lockout_active;
    end
    if (en.s2) begin
      power_s2 <= power_s1;
      lock_s2  <= lock_s1;
    end
    if (en.s3) begin
      lock_s3 <= lock_s2;
    end
    if (en.s4) begin
      lock_s4 <= lock_s3;
    end
  end

  for (genvar i = 0; i < mthd_pkg::CHANNELS; i++) begin : g_lane
    mthd_lane u_lane (
      .clk      (clk),
      .en       (en),
      .lane_id  (mthd_pkg::CHAN_W'(i)),
      .power_in (power_in),
      .rank     (rank_s2[i])
    );
  end

  mthd_merge u_merge (
    .clk       (clk),
    .en        (en),
    .gain      (threshold_gain),
    .power_s2  (power_s2),
    .rank_s2   (rank_s2),
    .thresh    (thresh_s4),
    .peak      (peak_s4),
    .peak_chan (chan_s4)
  );

  mthd_eval u_eval (
    .clk           (clk),
    .rst           (rst),
    .load          (en.s5 && s4_valid),
    .lockout       (lock_s4),
    .thresh        (thresh_s4),
    .peak          (peak_s4),
    .peak_chan     (chan_s4),
    .evaluated     (evaluated),
    .hit_flag      (hit_flag),
    .hit_channel   (hit_channel),
    .channel_count (channel_count),
    .start_lockout (start_lockout)
  );

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && s3_valid && s4_valid && out_valid && out_stall))
    else $error("input stalled while the pipeline has room");

  a_start_means_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && start_lockout) |-> (evaluated && hit_flag))
    else $error("lockout request without an evaluated hit");

  a_channel_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit_channel < 4'(mthd_pkg::CHANNELS)))
    else $error("hit channel out of range");

  a_locked_out_holds_flag: assert property (@(posedge clk) disable iff (rst)
    (en.s5 && s4_valid && lock_s4) |=> $stable(hit_flag) && $stable(hit_channel))
    else $error("state changed on a locked-out request");
`endif

endmodule

@@ sim/tb_median_threshold_hit_detector_top.sv @@
module tb_median_threshold_hit_detector_top;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_LEN    = 60;

  typedef struct packed {
    logic                 lockout;
    mthd_pkg::power_vec_t power;
  } power_set_t;

  typedef struct packed {
    logic             evaluated;
    logic             hit;
    logic [3:0]       channel;
    mthd_pkg::count_t count;
    logic             start;
  } hit_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  power_set_t  offer = '0;
  wire  [31:0] power_ch0 = offer.power[0];
  wire  [31:0] power_ch1 = offer.power[1];
  wire  [31:0] power_ch2 = offer.power[2];
  wire  [31:0] power_ch3 = offer.power[3];
  wire  [31:0] power_ch4 = offer.power[4];
  wire  [31:0] power_ch5 = offer.power[5];
  wire  [31:0] power_ch6 = offer.power[6];
  wire  [31:0] power_ch7 = offer.power[7];
  wire  [31:0] power_ch8 = offer.power[8];
  wire  [31:0] power_ch9 = offer.power[9];
  wire         lockout_active = offer.lockout;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        evaluated;
  logic        hit_flag;
  logic [3:0]  hit_channel;
  logic [15:0] channel_count;
  logic        start_lockout;

  // Predictor state, updated as each request is accepted.
  mthd_pkg::gain_t  gain_now = mthd_pkg::GAIN_RESET;
  logic             hit_seen = 1'b0;
  logic [3:0]       peak_chan = '0;
  mthd_pkg::count_t hits_per_chan [mthd_pkg::CHANNELS];

  power_set_t  pending_sets [$];
  hit_report_t expected_reports [$];
  hit_report_t predicted;
  hit_report_t observed;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_ticket = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int failures = 0;
  int sets_accepted = 0;
  int hits_predicted = 0;
  int locked_predicted = 0;
  int input_stalls = 0;
  int gains_used = 1;
  int cycle_count = 0;

  median_threshold_hit_detector_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .power_ch0     (power_ch0),
    .power_ch1     (power_ch1),
    .power_ch2     (power_ch2),
    .power_ch3     (power_ch3),
    .power_ch4     (power_ch4),
    .power_ch5     (power_ch5),
    .power_ch6     (power_ch6),
    .power_ch7     (power_ch7),
    .power_ch8     (power_ch8),
    .power_ch9     (power_ch9),
    .lockout_active(lockout_active),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .evaluated     (evaluated),
    .hit_flag      (hit_flag),
    .hit_channel   (hit_channel),
    .channel_count (channel_count),
    .start_lockout (start_lockout)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic mthd_pkg::power_vec_t ascending(mthd_pkg::power_vec_t v);
    mthd_pkg::power_t x;
    int               i;
    int               k;
    for (i = 1; i < mthd_pkg::CHANNELS; i++) begin
      x = v[i];
      k = i;
      while (k > 0 && v[k-1] > x) begin
        v[k] = v[k-1];
        k--;
      end
      v[k] = x;
    end
    return v;
  endfunction

  function automatic hit_report_t judge_power_set(power_set_t s);
    hit_report_t          r;
    mthd_pkg::power_vec_t ranked;
    logic [63:0]          bar;
    int                   top_ch;
    int                   c;
    r = '0;
    if (!s.lockout) begin
      r.evaluated = 1'b1;
      ranked = ascending(s.power);
      // Among equal maxima the highest channel ranks on top.
      top_ch = 0;
      for (c = 1; c < mthd_pkg::CHANNELS; c++) begin
        if (s.power[c] >= s.power[top_ch]) top_ch = c;
      end
      bar = 64'(ranked[mthd_pkg::MEDIAN_RANK]) * 64'(gain_now);
      if (64'(ranked[mthd_pkg::TOP_RANK]) > bar) begin
        peak_chan = 4'(top_ch);
        hits_per_chan[top_ch] = hits_per_chan[top_ch] + 1'b1;
        hit_seen = 1'b1;
        r.start = 1'b1;
      end else begin
        hit_seen = 1'b0;
      end
    end
    r.hit = hit_seen;
    r.channel = peak_chan;
    r.count = hits_per_chan[peak_chan];
    return r;
  endfunction

  function automatic mthd_pkg::power_t draw_power(int scale);
    case (scale)
      0: return mthd_pkg::power_t'($urandom_range(15));
      1: return mthd_pkg::power_t'($urandom_range(255));
      2: return mthd_pkg::power_t'($urandom_range(65535));
      default: return mthd_pkg::power_t'($urandom);
    endcase
  endfunction

  // Mostly sets with one channel placed just around the threshold that the
  // other nine form, so that hits and near misses both occur often.
  function automatic power_set_t make_peak_set(mthd_pkg::gain_t g);
    power_set_t           s;
    mthd_pkg::power_vec_t ranked;
    logic [63:0]          target;
    int                   scale;
    int                   shape;
    int                   peak;
    int                   c;
    s = '0;
    scale = $urandom_range(3);
    shape = $urandom_range(9);
    for (c = 0; c < mthd_pkg::CHANNELS; c++) begin
      case ($urandom_range(15))
        0: s.power[c] = '0;
        1: s.power[c] = '1;
        2: s.power[c] = (c == 0) ? draw_power(scale) : s.power[$urandom_range(c - 1)];
        default: s.power[c] = draw_power(scale);
      endcase
    end
    if (shape < 7) begin
      peak = $urandom_range(mthd_pkg::CHANNELS - 1);
      s.power[peak] = '1;
      ranked = ascending(s.power);
      target = 64'(ranked[mthd_pkg::MEDIAN_RANK]) * 64'(g);
      case ($urandom_range(3))
        0: target = target + 1;
        1: if (target != 0) target = target - 1;
        2: target = target + 64'($urandom_range(1000));
        default: ;
      endcase
      s.power[peak] = (target > 64'hFFFF_FFFF) ? '1 : target[31:0];
      if (shape == 6) s.power[$urandom_range(mthd_pkg::CHANNELS - 1)] = s.power[peak];
    end
    s.lockout = ($urandom_range(5) == 0);
    return s;
  endfunction

  function automatic power_set_t flat_set(mthd_pkg::power_t v);
    power_set_t s;
    int         c;
    s = '0;
    for (c = 0; c < mthd_pkg::CHANNELS; c++) s.power[c] = v;
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = judge_power_set(offer);
        expected_reports.push_back(predicted);
        sets_accepted++;
        if (predicted.start) hits_predicted++;
        if (!predicted.evaluated) locked_predicted++;
      end
      if (in_valid && in_stall) begin
        input_stalls++;
      end else if (pending_sets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer <= pending_sets.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          failures++;
          $error("result arrived with no request outstanding");
        end else begin
          observed = expected_reports.pop_front();
          check_field("evaluated", 32'(observed.evaluated), 32'(evaluated));
          check_field("hit_flag", 32'(observed.hit), 32'(hit_flag));
          check_field("hit_channel", 32'(observed.channel), 32'(hit_channel));
          check_field("channel_count", 32'(observed.count), 32'(channel_count));
          check_field("start_lockout", 32'(observed.start), 32'(start_lockout));
        end
      end
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_median_threshold_hit_detector_top failed");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_sets.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
  endtask

  task automatic enter_phase(bit write_gain, mthd_pkg::gain_t g, int send_pct, int recv_pct);
    wait_idle();
    if (write_gain) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= g;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      gain_now = g;
      gains_used++;
      @(negedge clk);
    end
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_sets.push_back(make_peak_set(gain_now));
  endtask

  // Freeze the output once the sender is well into the phase, so the
  // pipeline fills and the input side has to stall.
  task automatic hold_output_after(int k);
    int base;
    base = sets_accepted;
    while (sets_accepted < base + k) @(negedge clk);
    hold_ticket++;
  endtask

  initial begin
    power_set_t s;
    int         c;
    for (c = 0; c < mthd_pkg::CHANNELS; c++) hits_per_chan[c] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    enter_phase(1'b0, mthd_pkg::GAIN_RESET, 0, 0);
    pending_sets.push_back(flat_set('0));
    pending_sets.push_back(flat_set('1));
    s = flat_set('0);
    s.power[0] = 32'd1;
    pending_sets.push_back(s);
    s = flat_set('0);
    s.power[9] = '1;
    s.lockout = 1'b1;
    pending_sets.push_back(s);
    s.lockout = 1'b0;
    pending_sets.push_back(s);
    s = flat_set('0);
    s.power[2] = 32'd5000;
    s.power[7] = 32'd5000;
    pending_sets.push_back(s);
    // Peak exactly at median times gain, then one above it.
    s = flat_set(32'd5);
    s.power[4] = 32'd5000;
    pending_sets.push_back(s);
    s.power[4] = 32'd5001;
    pending_sets.push_back(s);
    s = flat_set(32'hA5A5_5A5A);
    s.lockout = 1'b1;
    pending_sets.push_back(s);
    for (c = 0; c < mthd_pkg::CHANNELS; c++) begin
      s = flat_set('0);
      s.power[c] = c[0] ? 32'h5555_5555 : 32'hAAAA_AAAA;
      pending_sets.push_back(s);
    end
    queue_random(175);

    enter_phase(1'b1, '0, 70, 0);
    pending_sets.push_back(flat_set('0));
    pending_sets.push_back(flat_set(32'd7));
    s = flat_set('0);
    s.power[5] = 32'd1;
    pending_sets.push_back(s);
    queue_random(100);

    enter_phase(1'b1, '1, 0, 70);
    // 65537 * 65535 is all ones, so only the smaller median gives a hit.
    s = flat_set(32'd65537);
    s.power[1] = '1;
    pending_sets.push_back(s);
    s = flat_set(32'd65536);
    s.power[1] = '1;
    pending_sets.push_back(s);
    queue_random(175);

    enter_phase(1'b1, mthd_pkg::gain_t'(1), 26, 26);
    queue_random(175);

    enter_phase(1'b1, mthd_pkg::GAIN_RESET, 0, 0);
    queue_random(175);
    hold_output_after(20);

    enter_phase(1'b1, mthd_pkg::gain_t'($urandom_range(2, 5000)), 70, 70);
    queue_random(150);

    enter_phase(1'b1, mthd_pkg::gain_t'($urandom), 0, 26);
    queue_random(125);
    hold_output_after(40);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Checked %0d power sets under %0d gain settings: %0d hits, %0d locked out.",
             sets_accepted, gains_used, hits_predicted, locked_predicted);
    $display("Input was held back for %0d cycles while the output was frozen or slow.",
             input_stalls);
    if (failures == 0) begin
      $display("tb_median_threshold_hit_detector_top passed");
    end else begin
      $display("tb_median_threshold_hit_detector_top failed");
    end
    $finish;
  end

endmodule
